/* sv/pip_pkg.sv */
// ============================================================================
// pip_pkg
// Shared types and constants for the point-in-polygon test unit.
// ============================================================================
package pip_pkg;

	// Polygon capacity and derived widths
	localparam int MAX_VERTICES = 64;
	localparam int COORD_W      = 32;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int ADDR_W       = $clog2(MAX_VERTICES);

	// Function codes of an input word
	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	// One stored vertex
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vertex_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

/* sv/point_in_polygon_test_unit.sv */
// Clear and append words complete on accept; the unit stays ready for more.
// A query over n >= 1 stored vertices makes n + 1 vertex reads, closing edge
// included, then drains the edge datapath before it loads its result; an empty
// polygon loads its result with no reads. The next word is taken once the result
// is loaded, later while an unread result holds the output.
// Reset clears the vertex count, the overflow flag and all handshake control.
// ============================================================================
// point_in_polygon_test_unit
// Crossing-number point-in-polygon test with boundary detection over a
// polygon held in an on-chip vertex memory.
// ============================================================================
module point_in_polygon_test_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            func,
	input  logic signed [pip_pkg::COORD_W-1:0]    coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0]    coord_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  inside_res,
	output logic                                  on_boundary,
	output logic                                  overflowed
);

	import pip_pkg::*;

	state_t state_q, state_nx;

	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic signed [COORD_W-1:0] qx_q, qy_q;

	logic              in_fire;
	logic              start_query;
	logic              issue;
	logic              load_out;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	vertex_t           ram_wdata;
	vertex_t           ram_rdata;

	// Read pipeline
	logic              rd_v_s0, rd_edge_s0;
	vertex_t           prev_q;
	logic              ev_s1, ev_s2;
	logic signed [COORD_W:0]     dx_vu, dy_qu, dy_vu, dx_qu;
	logic signed [COORD_W:0]     dx_vu_s1, dy_qu_s1, dy_vu_s1, dx_qu_s1;
	logic              c1, c2, bbox;
	logic              c1_s1, c2_s1, bbox_s1;
	logic              c1_s2, c2_s2, bbox_s2;
	logic signed [2*COORD_W+1:0] p1_s2, p2_s2;
	logic signed [2*COORD_W+2:0] cross_d;
	logic              cross_zero, cross_neg, cross_pos;
	logic              boundary_q, parity_q;

	// Output register
	logic              out_valid_q, inside_q, on_q, ovf_out_q;

	// Vertex memory
	pip_ram #(
		.WIDTH($bits(vertex_t)),
		.DEPTH(MAX_VERTICES)
	) u_vtx_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_query) begin
					state_nx = (count_q == '0) ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (rd_idx_q == count_q) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_v_s0 && !ev_s1 && !ev_s2) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_RUN:   issue    = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_fire     = in_valid && in_ready;
	assign start_query = in_fire && (func == FUNC_QUERY);

	// Append writes at the current count while there is room
	assign ram_we      = in_fire && (func == FUNC_APPEND) && (count_q < CNT_W'(MAX_VERTICES));
	assign ram_waddr   = count_q[ADDR_W-1:0];
	assign ram_wdata   = '{x: coord_x, y: coord_y};
	// Last read wraps to vertex zero for the closing edge
	assign ram_raddr   = (rd_idx_q == count_q) ? '0 : rd_idx_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_nx;
			if (in_fire) begin
				case (func)
					FUNC_CLEAR: begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
					FUNC_APPEND: begin
						if (count_q < CNT_W'(MAX_VERTICES)) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			// Advance the read index over the polygon
			if (start_query) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
		end
	end

	// Hold the query point
	always_ff @(posedge clk) begin
		if (start_query) begin
			qx_q <= coord_x;
			qy_q <= coord_y;
		end
	end

	// Edge datapath: u is the previous vertex, v the one just read
	assign dx_vu = $signed({ram_rdata.x[COORD_W-1], ram_rdata.x})
	             - $signed({prev_q.x[COORD_W-1], prev_q.x});
	assign dy_vu = $signed({ram_rdata.y[COORD_W-1], ram_rdata.y})
	             - $signed({prev_q.y[COORD_W-1], prev_q.y});
	assign dx_qu = $signed({qx_q[COORD_W-1], qx_q})
	             - $signed({prev_q.x[COORD_W-1], prev_q.x});
	assign dy_qu = $signed({qy_q[COORD_W-1], qy_q})
	             - $signed({prev_q.y[COORD_W-1], prev_q.y});

	assign c1   = (prev_q.x < qx_q) && (ram_rdata.x >= qx_q);
	assign c2   = (prev_q.x >= qx_q) && (ram_rdata.x < qx_q);
	assign bbox = ((prev_q.x <= qx_q && qx_q <= ram_rdata.x)
	            || (ram_rdata.x <= qx_q && qx_q <= prev_q.x))
	           && ((prev_q.y <= qy_q && qy_q <= ram_rdata.y)
	            || (ram_rdata.y <= qy_q && qy_q <= prev_q.y));

	// Sign of the cross product of (v - u) and (q - u)
	assign cross_d    = $signed({p1_s2[2*COORD_W+1], p1_s2})
	                  - $signed({p2_s2[2*COORD_W+1], p2_s2});
	assign cross_zero = (cross_d == '0);
	assign cross_neg  = cross_d[2*COORD_W+2];
	assign cross_pos  = !cross_zero && !cross_neg;

	// Pipeline valids and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s0    <= 1'b0;
			rd_edge_s0 <= 1'b0;
			ev_s1      <= 1'b0;
			ev_s2      <= 1'b0;
			boundary_q <= 1'b0;
			parity_q   <= 1'b0;
		end else begin
			rd_v_s0    <= issue;
			rd_edge_s0 <= issue && (rd_idx_q != '0);
			ev_s1      <= rd_v_s0 && rd_edge_s0;
			ev_s2      <= ev_s1;
			if (start_query) begin
				boundary_q <= 1'b0;
				parity_q   <= 1'b0;
			end else if (ev_s2) begin
				boundary_q <= boundary_q || (cross_zero && bbox_s2);
				parity_q   <= parity_q ^ ((c1_s2 && cross_neg) || (c2_s2 && cross_pos));
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (rd_v_s0) begin
			prev_q <= ram_rdata;
		end
		dx_vu_s1 <= dx_vu;
		dy_qu_s1 <= dy_qu;
		dy_vu_s1 <= dy_vu;
		dx_qu_s1 <= dx_qu;
		c1_s1    <= c1;
		c2_s1    <= c2;
		bbox_s1  <= bbox;
		p1_s2    <= dx_vu_s1 * dy_qu_s1;
		p2_s2    <= dy_vu_s1 * dx_qu_s1;
		c1_s2    <= c1_s1;
		c2_s2    <= c2_s1;
		bbox_s2  <= bbox_s1;
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			inside_q  <= boundary_q || parity_q;
			on_q      <= boundary_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign inside_res  = inside_q;
	assign on_boundary = on_q;
	assign overflowed  = ovf_out_q;

endmodule

/* sv/pip_ram.sv */
// ============================================================================
// pip_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module pip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on request, register the read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
